FILE: hw/rtl/mbs_pkg.sv
package mbs_pkg;

  // Configuration register file
  localparam int CFG_W  = 11;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BAND_ROWS    = 2'd2;

  // Result fields
  localparam int STEER_W = 2;
  localparam int MEAN_W  = 10;
  localparam int ROWS_W  = 11;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [STEER_W-1:0] STEER_FORWARD = 2'd0;
  localparam logic [STEER_W-1:0] STEER_LEFT    = 2'd1;
  localparam logic [STEER_W-1:0] STEER_RIGHT   = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] band_rows;
  } cfg_t;

  typedef struct packed {
    logic pix_take;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/mbs_cfg.sv
module mbs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbs_pkg::APB_AW-1:0]    paddr,
  input  logic [mbs_pkg::APB_DW-1:0]    pwdata,
  output logic [mbs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output mbs_pkg::cfg_t                 cfg_o
);

  logic [mbs_pkg::CFG_W-1:0] width_q, height_q, band_q;
  logic [1:0]                idx;
  logic                      wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbs_pkg::CFG_W'(320);
      height_q <= mbs_pkg::CFG_W'(180);
      band_q   <= mbs_pkg::CFG_W'(70);
    end else if (wr_en) begin
      case (idx)
        mbs_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[mbs_pkg::CFG_W-1:0];
        mbs_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[mbs_pkg::CFG_W-1:0];
        mbs_pkg::REG_BAND_ROWS:    band_q   <= pwdata[mbs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mbs_pkg::REG_FRAME_WIDTH:  prdata = mbs_pkg::APB_DW'(width_q);
      mbs_pkg::REG_FRAME_HEIGHT: prdata = mbs_pkg::APB_DW'(height_q);
      mbs_pkg::REG_BAND_ROWS:    prdata = mbs_pkg::APB_DW'(band_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o.frame_width  = width_q;
  assign cfg_o.frame_height = height_q;
  assign cfg_o.band_rows    = band_q;

endmodule

FILE: hw/rtl/mbs_ctrl.sv
module mbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mbs_pkg::dp_status_t    status_i,
  output mbs_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_ACCUM = 3'b001,
    ST_DIV   = 3'b010,
    ST_LOAD  = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        // The last pixel of a frame waits until the previous result is gone.
        in_ready_o     = !(status_i.frame_end && status_i.out_busy);
        cmd_o.pix_take = in_valid_i && in_ready_o;
        if (cmd_o.pix_take && status_i.frame_end) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_ACCUM;
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/mbs_datapath.sv
module mbs_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MIN_ROWS   = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbs_pkg::cfg_t                  cfg_i,
  input  logic                           pixel_white_i,
  input  mbs_pkg::ctrl_cmd_t             cmd_i,
  output mbs_pkg::dp_status_t            status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [mbs_pkg::STEER_W-1:0]    steer_o,
  output logic [mbs_pkg::MEAN_W-1:0]     mean_column_o,
  output logic [mbs_pkg::ROWS_W-1:0]     rows_accepted_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WD_W   = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HT_W   = ROW_W + 1;
  localparam int SUM_W  = COL_W + 1 + ROW_W;
  localparam int DVD_W  = SUM_W - 1;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int WX_W   = (WD_W > mbs_pkg::CFG_W) ? WD_W : mbs_pkg::CFG_W;
  localparam int HX_W   = (HT_W > mbs_pkg::CFG_W) ? HT_W : mbs_pkg::CFG_W;
  localparam int BS_W   = HX_W + 1;

  // Frame scan state
  logic [COL_W-1:0]  col_q, first_q, last_q;
  logic [ROW_W-1:0]  row_q, acc_q;
  logic              has_q;
  logic [SUM_W-1:0]  sum_q;

  // Divider and result state
  logic [DVD_W-1:0]  dvd_q;
  logic [ROW_W-1:0]  rem_q, divr_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              enough_q;
  logic              out_valid_q;
  logic [mbs_pkg::STEER_W-1:0] steer_q;
  logic [mbs_pkg::MEAN_W-1:0]  mean_q;
  logic [mbs_pkg::ROWS_W-1:0]  rows_q;

  logic [WX_W-1:0]   w_x;
  logic [HX_W-1:0]   h_x;
  logic [WD_W-1:0]   w, wm1, lim4;
  logic [HT_W-1:0]   h, hm1;
  logic              col_end, row_end;
  logic signed [BS_W-1:0] lim_s, row_s;
  logic              in_band, row_ok;
  logic [COL_W-1:0]  first_cur, last_cur, diff;
  logic              has_cur;
  logic [COL_W:0]    pair;
  logic [SUM_W-1:0]  sum_next;
  logic [ROW_W-1:0]  acc_next;
  logic              enough_next;
  logic [ROW_W:0]    trial;
  logic              ge;
  logic [COL_W-1:0]  q;
  logic [COL_W+1:0]  m3;
  logic              go_right, go_left;
  logic [mbs_pkg::STEER_W-1:0] steer_new;

  always_comb begin
    w_x = WX_W'(cfg_i.frame_width);
    if (w_x == '0) begin
      w_x = WX_W'(1);
    end else if (w_x > WX_W'(MAX_WIDTH)) begin
      w_x = WX_W'(MAX_WIDTH);
    end
    h_x = HX_W'(cfg_i.frame_height);
    if (h_x == '0) begin
      h_x = HX_W'(1);
    end else if (h_x > HX_W'(MAX_HEIGHT)) begin
      h_x = HX_W'(MAX_HEIGHT);
    end
  end

  assign w       = w_x[WD_W-1:0];
  assign h       = h_x[HT_W-1:0];
  assign wm1     = w - 1'b1;
  assign hm1     = h - 1'b1;
  assign col_end = {1'b0, col_q} >= wm1;
  assign row_end = {1'b0, row_q} >= hm1;

  // A row is in the band when its index lies above height minus band rows and is not row 0.
  assign lim_s   = $signed(BS_W'(h)) - $signed(BS_W'(cfg_i.band_rows));
  assign row_s   = $signed(BS_W'(row_q));
  assign in_band = (row_s > lim_s) && (row_q != '0);

  assign has_cur   = has_q || pixel_white_i;
  assign first_cur = (pixel_white_i && !has_q) ? col_q : first_q;
  assign last_cur  = pixel_white_i ? col_q : last_q;
  assign diff      = last_cur - first_cur;
  // last - first - 2 < w/4 rewritten without a negative intermediate.
  assign lim4      = (w >> 2) + WD_W'(2);
  assign row_ok    = col_end && in_band && has_cur && ({1'b0, diff} < lim4) &&
                     (last_cur >= COL_W'(2));

  assign pair        = {1'b0, first_cur} + {1'b0, last_cur};
  assign sum_next    = sum_q + (row_ok ? SUM_W'(pair) : '0);
  assign acc_next    = acc_q + ROW_W'(row_ok);
  assign enough_next = 32'(acc_next) > 32'(MIN_ROWS);

  // Restoring divider, one quotient bit per step.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, divr_q};

  // mean > floor(2w/3) is 3*mean > 2w; mean < floor(w/3) is 3*mean + 3 <= w.
  assign q        = dvd_q[COL_W-1:0];
  assign m3       = ({2'b00, q} << 1) + {2'b00, q};
  assign go_right = {w, 1'b0} < m3;
  assign go_left  = ((COL_W+3)'(m3) + (COL_W+3)'(3)) <= (COL_W+3)'(w);

  always_comb begin
    if (!enough_q || go_left) begin
      steer_new = mbs_pkg::STEER_LEFT;
    end else if (go_right) begin
      steer_new = mbs_pkg::STEER_RIGHT;
    end else begin
      steer_new = mbs_pkg::STEER_FORWARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
      has_q   <= 1'b0;
      sum_q   <= '0;
      acc_q   <= '0;
    end else if (cmd_i.pix_take) begin
      if (col_end) begin
        col_q   <= '0;
        first_q <= '0;
        last_q  <= '0;
        has_q   <= 1'b0;
        if (row_end) begin
          row_q <= '0;
          sum_q <= '0;
          acc_q <= '0;
        end else begin
          row_q <= row_q + 1'b1;
          sum_q <= sum_next;
          acc_q <= acc_next;
        end
      end else begin
        col_q   <= col_q + 1'b1;
        first_q <= first_cur;
        last_q  <= last_cur;
        has_q   <= has_cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take && col_end && row_end) begin
      dvd_q    <= sum_next[SUM_W-1:1];
      divr_q   <= acc_next;
      rem_q    <= '0;
      dcnt_q   <= DCNT_W'(DVD_W - 1);
      enough_q <= enough_next;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? ROW_W'(trial - {1'b0, divr_q}) : trial[ROW_W-1:0];
      dvd_q  <= {dvd_q[DVD_W-2:0], ge};
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      steer_q <= steer_new;
      mean_q  <= enough_q ? mbs_pkg::MEAN_W'(q) : '0;
      rows_q  <= mbs_pkg::ROWS_W'(divr_q);
    end
  end

  assign status_o.frame_end = col_end && row_end;
  assign status_o.div_last  = (dcnt_q == '0);
  assign status_o.out_busy  = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign steer_o         = steer_q;
  assign mean_column_o   = mean_q;
  assign rows_accepted_o = rows_q;

endmodule

FILE: hw/rtl/mask_band_steering.sv
// Channel   Dir  Word                                   Handshake
// s_axis    in   tdata[0] pixel_white, raster order     tvalid/tready
// m_axis    out  steer, mean_column, rows_accepted      tvalid/tready
// apb       in   frame_width, frame_height, band_rows   psel/penable, pready=1
//
// One pixel is taken per cycle while a frame is scanned.
// After the last pixel of a frame the input stalls for the restoring divider,
// one quotient bit per cycle, and while the result register is loaded.
// The last pixel of a frame is held off while the previous result is not taken.
// Reset returns the registers to 320 x 180 with a 70-row band and starts a frame.
module mask_band_steering #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MIN_ROWS   = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] pixel_white, [7:1] zero
  input  logic [mbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] steer, [11:2] mean_column, [22:12] rows_accepted, [23] zero
  output logic [mbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbs_pkg::APB_AW-1:0]        paddr,
  input  logic [mbs_pkg::APB_DW-1:0]        pwdata,
  output logic [mbs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  mbs_pkg::cfg_t       cfg;
  mbs_pkg::ctrl_cmd_t  cmd;
  mbs_pkg::dp_status_t status;
  logic [mbs_pkg::STEER_W-1:0] steer;
  logic [mbs_pkg::MEAN_W-1:0]  mean_column;
  logic [mbs_pkg::ROWS_W-1:0]  rows_accepted;

  mbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MIN_ROWS   (MIN_ROWS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .pixel_white_i   (s_axis_tdata[0]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .steer_o         (steer),
    .mean_column_o   (mean_column),
    .rows_accepted_o (rows_accepted)
  );

  assign m_axis_tdata = {1'b0, rows_accepted, mean_column, steer};

endmodule

FILE: hw/rtl/mbs_checker.sv
module mbs_checker #(
  parameter int MIN_ROWS = 5
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              pready
);

  // A word waiting for the sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_steer_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == mbs_pkg::STEER_FORWARD ||
                       m_axis_tdata[1:0] == mbs_pkg::STEER_LEFT ||
                       m_axis_tdata[1:0] == mbs_pkg::STEER_RIGHT))
    else $error("steer field holds an unused code");

  // Too few accepted rows always means a left turn with a zero mean.
  a_few_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (32'(m_axis_tdata[22:12]) <= 32'(MIN_ROWS)) |->
      m_axis_tdata[1:0] == mbs_pkg::STEER_LEFT && m_axis_tdata[11:2] == '0)
    else $error("decision made on too few rows");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23] == 1'b0 && pready)
    else $error("pad bit set or configuration port not ready");

endmodule

bind mask_band_steering mbs_checker #(.MIN_ROWS(MIN_ROWS)) u_mbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
